### rtl/vnsc_pkg.sv
// shared constants, register codes and the control struct of the seed cell chain
package vnsc_pkg;

   localparam int MAX_SEEDS_DEF  = 64;
   localparam int COORD_BITS_DEF = 12;

   localparam int SLOT_W      = 6;
   localparam int SLOT_LIMIT  = 64;
   localparam int WIDTH_W     = 13;
   localparam int COUNT_W     = 7;
   localparam int COLOR_W     = 32;
   localparam int DIST_OUT_W  = 25;
   localparam int LIMIT_W     = 2 * WIDTH_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd256;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd0;
   localparam logic [COLOR_W-1:0] EMPTY_RESET = 32'd0;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH = 2'd0,
      CSR_SEED_COUNT  = 2'd1,
      CSR_EMPTY_COLOR = 2'd2
   } csr_index_type;

   // control bits that travel with an item down the chain
   typedef struct packed {
      logic valid;
      logic query;
      logic hit;
   } item_ctrl_type;

endpackage

### rtl/vnsc_if.sv
// valid/ready channel interfaces for requests, responses and register writes
interface vnsc_req_if #(
   parameter int COORD_BITS = vnsc_pkg::COORD_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [vnsc_pkg::SLOT_W-1:0]   seed_index;
   logic [COORD_BITS-1:0]         seed_x;
   logic [COORD_BITS-1:0]         seed_y;
   logic [vnsc_pkg::COLOR_W-1:0]  seed_color;
   logic [COORD_BITS-1:0]         pixel_x;
   logic [COORD_BITS-1:0]         pixel_y;

   modport source (output valid, kind, seed_index, seed_x, seed_y, seed_color,
                   pixel_x, pixel_y, input ready);
   modport sink   (input valid, kind, seed_index, seed_x, seed_y, seed_color,
                   pixel_x, pixel_y, output ready);
endinterface

interface vnsc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [vnsc_pkg::COLOR_W-1:0]    color_out;
   logic                            found;
   logic [vnsc_pkg::SLOT_W-1:0]     nearest_index;
   logic [vnsc_pkg::DIST_OUT_W-1:0] distance_squared;

   modport source (output valid, color_out, found, nearest_index, distance_squared,
                   input ready);
   modport sink   (input valid, color_out, found, nearest_index, distance_squared,
                   output ready);
endinterface

interface vnsc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [vnsc_pkg::CSR_INDEX_W-1:0] index;
   logic [vnsc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/vnsc_cell.sv
// one seed cell: holds a seed, squares the offsets, then updates the running best
module vnsc_cell #(
   parameter int K          = 0,
   parameter int COORD_BITS = vnsc_pkg::COORD_BITS_DEF,
   parameter int CMP_W      = vnsc_pkg::LIMIT_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [vnsc_pkg::COUNT_W-1:0]      seed_count,
   input  logic [vnsc_pkg::LIMIT_W-1:0]      limit,
   input  vnsc_pkg::item_ctrl_type           in_ctrl,
   input  logic [vnsc_pkg::SLOT_W-1:0]       in_slot,
   input  logic [COORD_BITS-1:0]             in_sx,
   input  logic [COORD_BITS-1:0]             in_sy,
   input  logic [vnsc_pkg::COLOR_W-1:0]      in_color,
   input  logic [COORD_BITS-1:0]             in_px,
   input  logic [COORD_BITS-1:0]             in_py,
   input  logic [CMP_W-1:0]                  in_best_d,
   input  logic [vnsc_pkg::SLOT_W-1:0]       in_best_i,
   input  logic [vnsc_pkg::COLOR_W-1:0]      in_best_c,
   output vnsc_pkg::item_ctrl_type           out_ctrl,
   output logic [vnsc_pkg::SLOT_W-1:0]       out_slot,
   output logic [COORD_BITS-1:0]             out_sx,
   output logic [COORD_BITS-1:0]             out_sy,
   output logic [vnsc_pkg::COLOR_W-1:0]      out_color,
   output logic [COORD_BITS-1:0]             out_px,
   output logic [COORD_BITS-1:0]             out_py,
   output logic [CMP_W-1:0]                  out_best_d,
   output logic [vnsc_pkg::SLOT_W-1:0]       out_best_i,
   output logic [vnsc_pkg::COLOR_W-1:0]      out_best_c
);

   localparam int SQ_W = 2 * COORD_BITS;
   localparam logic [vnsc_pkg::SLOT_W-1:0] CELL_SLOT =
      vnsc_pkg::SLOT_W'(K % vnsc_pkg::SLOT_LIMIT);
   localparam bit SLOT_REACHABLE = (K < vnsc_pkg::SLOT_LIMIT);

   // stored seed, undefined until loaded
   logic [COORD_BITS-1:0]        seed_x_ff, seed_y_ff;
   logic [vnsc_pkg::COLOR_W-1:0] seed_c_ff;

   // first half: squared offsets
   vnsc_pkg::item_ctrl_type      a_ctrl_ff;
   logic [vnsc_pkg::SLOT_W-1:0]  a_slot_ff;
   logic [COORD_BITS-1:0]        a_sx_ff, a_sy_ff, a_px_ff, a_py_ff;
   logic [vnsc_pkg::COLOR_W-1:0] a_color_ff;
   logic [SQ_W-1:0]              a_dx2_ff, a_dy2_ff;
   logic [CMP_W-1:0]             a_best_d_ff;
   logic [vnsc_pkg::SLOT_W-1:0]  a_best_i_ff;
   logic [vnsc_pkg::COLOR_W-1:0] a_best_c_ff;

   // second half: running best
   vnsc_pkg::item_ctrl_type      b_ctrl_ff;
   logic [vnsc_pkg::SLOT_W-1:0]  b_slot_ff;
   logic [COORD_BITS-1:0]        b_sx_ff, b_sy_ff, b_px_ff, b_py_ff;
   logic [vnsc_pkg::COLOR_W-1:0] b_color_ff;
   logic [CMP_W-1:0]             b_best_d_ff;
   logic [vnsc_pkg::SLOT_W-1:0]  b_best_i_ff;
   logic [vnsc_pkg::COLOR_W-1:0] b_best_c_ff;

   logic                  load_here;
   logic [COORD_BITS-1:0] dx, dy;
   logic                  cell_on;
   logic [CMP_W-1:0]      cand_d, bound;
   logic                  take;

   vnsc_pkg::item_ctrl_type      b_ctrl_in;
   logic [CMP_W-1:0]             b_best_d_in;
   logic [vnsc_pkg::SLOT_W-1:0]  b_best_i_in;
   logic [vnsc_pkg::COLOR_W-1:0] b_best_c_in;

   assign load_here = SLOT_REACHABLE && in_ctrl.valid &&
                      (in_ctrl.query == vnsc_pkg::KIND_LOAD) && (in_slot == CELL_SLOT);
   assign dx = (in_px > seed_x_ff) ? (in_px - seed_x_ff) : (seed_x_ff - in_px);
   assign dy = (in_py > seed_y_ff) ? (in_py - seed_y_ff) : (seed_y_ff - in_py);

   always_ff @(posedge clock) begin
      if (advance && load_here) begin
         seed_x_ff <= in_sx;
         seed_y_ff <= in_sy;
         seed_c_ff <= in_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctrl_ff <= '0;
      end else if (advance) begin
         a_ctrl_ff <= in_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_slot_ff   <= in_slot;
         a_sx_ff     <= in_sx;
         a_sy_ff     <= in_sy;
         a_color_ff  <= in_color;
         a_px_ff     <= in_px;
         a_py_ff     <= in_py;
         a_dx2_ff    <= SQ_W'(dx) * SQ_W'(dx);
         a_dy2_ff    <= SQ_W'(dy) * SQ_W'(dy);
         a_best_d_ff <= in_best_d;
         a_best_i_ff <= in_best_i;
         a_best_c_ff <= in_best_c;
      end
   end

   // strict compare keeps the lower slot on a tie
   assign cell_on = (32'(K) < 32'(seed_count));
   assign cand_d  = CMP_W'(a_dx2_ff) + CMP_W'(a_dy2_ff);
   assign bound   = a_ctrl_ff.hit ? a_best_d_ff : CMP_W'(limit);
   assign take    = a_ctrl_ff.valid && a_ctrl_ff.query && cell_on && (cand_d < bound);

   always_comb begin
      b_ctrl_in   = a_ctrl_ff;
      b_best_d_in = a_best_d_ff;
      b_best_i_in = a_best_i_ff;
      b_best_c_in = a_best_c_ff;
      if (take) begin
         b_ctrl_in.hit = 1'b1;
         b_best_d_in   = cand_d;
         b_best_i_in   = CELL_SLOT;
         b_best_c_in   = seed_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctrl_ff <= '0;
      end else if (advance) begin
         b_ctrl_ff <= b_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_slot_ff   <= a_slot_ff;
         b_sx_ff     <= a_sx_ff;
         b_sy_ff     <= a_sy_ff;
         b_color_ff  <= a_color_ff;
         b_px_ff     <= a_px_ff;
         b_py_ff     <= a_py_ff;
         b_best_d_ff <= b_best_d_in;
         b_best_i_ff <= b_best_i_in;
         b_best_c_ff <= b_best_c_in;
      end
   end

   assign out_ctrl   = b_ctrl_ff;
   assign out_slot   = b_slot_ff;
   assign out_sx     = b_sx_ff;
   assign out_sy     = b_sy_ff;
   assign out_color  = b_color_ff;
   assign out_px     = b_px_ff;
   assign out_py     = b_py_ff;
   assign out_best_d = b_best_d_ff;
   assign out_best_i = b_best_i_ff;
   assign out_best_c = b_best_c_ff;

endmodule

### rtl/voronoi_nearest_seed_color_unit.sv
// top level: nearest-seed color lookup over a chain of seed cells
//
//   channel  dir  moves per transfer
//   -------  ---  ----------------------------------------------------------
//   req_if   in   seed load (kind 0) or pixel query (kind 1)
//   rsp_if   out  color_out, found, nearest_index, distance_squared per query
//   csr_if   in   register write: image_width, seed_count, empty_color
//
// one item enters per cycle while rsp_if is not stalled; a query's result
// passes two register stages per cell and then the output register. loads
// travel the same chain and write their cell on the way, so loads and queries
// keep their order.
// reset is synchronous: clears item valid bits and loads register defaults;
// the seed table is not cleared. a held response freezes the whole chain.
module voronoi_nearest_seed_color_unit #(
   parameter int MAX_SEEDS  = vnsc_pkg::MAX_SEEDS_DEF,
   parameter int COORD_BITS = vnsc_pkg::COORD_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   vnsc_req_if.sink  req_if,
   vnsc_rsp_if.source rsp_if,
   vnsc_csr_if.sink  csr_if
);

   localparam int DIST_W = 2 * COORD_BITS + 1;
   localparam int CMP_W  = (DIST_W > vnsc_pkg::LIMIT_W) ? DIST_W : vnsc_pkg::LIMIT_W;

   // configuration registers
   logic [vnsc_pkg::WIDTH_W-1:0] image_width_ff, image_width_in;
   logic [vnsc_pkg::COUNT_W-1:0] seed_count_ff, seed_count_in;
   logic [vnsc_pkg::COLOR_W-1:0] empty_color_ff, empty_color_in;
   logic [vnsc_pkg::LIMIT_W-1:0] limit_ff;

   // output register
   logic                            out_valid_ff;
   logic [vnsc_pkg::COLOR_W-1:0]    out_color_ff;
   logic                            out_found_ff;
   logic [vnsc_pkg::SLOT_W-1:0]     out_index_ff;
   logic [vnsc_pkg::DIST_OUT_W-1:0] out_dist_ff;

   logic advance;

   // links between cells; entry 0 is the request side
   vnsc_pkg::item_ctrl_type      ctrl_link   [0:MAX_SEEDS];
   logic [vnsc_pkg::SLOT_W-1:0]  slot_link   [0:MAX_SEEDS];
   logic [COORD_BITS-1:0]        sx_link     [0:MAX_SEEDS];
   logic [COORD_BITS-1:0]        sy_link     [0:MAX_SEEDS];
   logic [vnsc_pkg::COLOR_W-1:0] color_link  [0:MAX_SEEDS];
   logic [COORD_BITS-1:0]        px_link     [0:MAX_SEEDS];
   logic [COORD_BITS-1:0]        py_link     [0:MAX_SEEDS];
   logic [CMP_W-1:0]             best_d_link [0:MAX_SEEDS];
   logic [vnsc_pkg::SLOT_W-1:0]  best_i_link [0:MAX_SEEDS];
   logic [vnsc_pkg::COLOR_W-1:0] best_c_link [0:MAX_SEEDS];

   // register writes are always taken; an index past the list is dropped
   assign csr_if.ready = 1'b1;

   always_comb begin
      image_width_in = image_width_ff;
      seed_count_in  = seed_count_ff;
      empty_color_in = empty_color_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            vnsc_pkg::CSR_IMAGE_WIDTH: begin
               image_width_in = csr_if.data[vnsc_pkg::WIDTH_W-1:0];
            end
            vnsc_pkg::CSR_SEED_COUNT: begin
               seed_count_in = csr_if.data[vnsc_pkg::COUNT_W-1:0];
            end
            vnsc_pkg::CSR_EMPTY_COLOR: begin
               empty_color_in = csr_if.data[vnsc_pkg::COLOR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= vnsc_pkg::WIDTH_RESET;
         seed_count_ff  <= vnsc_pkg::COUNT_RESET;
         empty_color_ff <= vnsc_pkg::EMPTY_RESET;
      end else begin
         image_width_ff <= image_width_in;
         seed_count_ff  <= seed_count_in;
         empty_color_ff <= empty_color_in;
      end
   end

   // squared cutoff, registered from the image width register
   always_ff @(posedge clock) begin
      limit_ff <= vnsc_pkg::LIMIT_W'(image_width_ff) * vnsc_pkg::LIMIT_W'(image_width_ff);
   end

   // the chain moves whenever the output register can take its tail
   assign advance      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;

   // chain head: a new item starts with no hit and the empty color
   assign ctrl_link[0].valid  = req_if.valid;
   assign ctrl_link[0].query  = req_if.kind;
   assign ctrl_link[0].hit    = 1'b0;
   assign slot_link[0]        = req_if.seed_index;
   assign sx_link[0]          = req_if.seed_x;
   assign sy_link[0]          = req_if.seed_y;
   assign color_link[0]       = req_if.seed_color;
   assign px_link[0]          = req_if.pixel_x;
   assign py_link[0]          = req_if.pixel_y;
   assign best_d_link[0]      = '0;
   assign best_i_link[0]      = '0;
   assign best_c_link[0]      = empty_color_ff;

   for (genvar g = 0; g < MAX_SEEDS; g++) begin : g_cell
      vnsc_cell #(
         .K          (g),
         .COORD_BITS (COORD_BITS),
         .CMP_W      (CMP_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .seed_count (seed_count_ff),
         .limit      (limit_ff),
         .in_ctrl    (ctrl_link[g]),
         .in_slot    (slot_link[g]),
         .in_sx      (sx_link[g]),
         .in_sy      (sy_link[g]),
         .in_color   (color_link[g]),
         .in_px      (px_link[g]),
         .in_py      (py_link[g]),
         .in_best_d  (best_d_link[g]),
         .in_best_i  (best_i_link[g]),
         .in_best_c  (best_c_link[g]),
         .out_ctrl   (ctrl_link[g+1]),
         .out_slot   (slot_link[g+1]),
         .out_sx     (sx_link[g+1]),
         .out_sy     (sy_link[g+1]),
         .out_color  (color_link[g+1]),
         .out_px     (px_link[g+1]),
         .out_py     (py_link[g+1]),
         .out_best_d (best_d_link[g+1]),
         .out_best_i (best_i_link[g+1]),
         .out_best_c (best_c_link[g+1])
      );
   end

   // chain tail: only queries leave a result, loads end here
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= ctrl_link[MAX_SEEDS].valid && ctrl_link[MAX_SEEDS].query;
      end
   end

   // index and distance start at zero and change only on a hit
   always_ff @(posedge clock) begin
      if (advance) begin
         out_color_ff <= best_c_link[MAX_SEEDS];
         out_found_ff <= ctrl_link[MAX_SEEDS].hit;
         out_index_ff <= best_i_link[MAX_SEEDS];
         out_dist_ff  <= best_d_link[MAX_SEEDS][vnsc_pkg::DIST_OUT_W-1:0];
      end
   end

   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.color_out        = out_color_ff;
   assign rsp_if.found            = out_found_ff;
   assign rsp_if.nearest_index    = out_index_ff;
   assign rsp_if.distance_squared = out_dist_ff;

endmodule

### rtl/vnsc_checker.sv
// port-level checks of the nearest-seed unit, bound to the top level
module vnsc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_found,
   input logic [vnsc_pkg::SLOT_W-1:0]     rsp_nearest_index,
   input logic [vnsc_pkg::DIST_OUT_W-1:0] rsp_distance_squared
);

   // a held response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // requests are refused only while a response waits
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request side blocked without a stalled response");

   // a miss reports slot zero and distance zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_nearest_index == '0 && rsp_distance_squared == '0)
      else $error("miss carries a slot or distance");

   // reset empties the output
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind voronoi_nearest_seed_color_unit vnsc_checker u_vnsc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_if.ready),
   .rsp_valid            (rsp_if.valid),
   .rsp_ready            (rsp_if.ready),
   .rsp_found            (rsp_if.found),
   .rsp_nearest_index    (rsp_if.nearest_index),
   .rsp_distance_squared (rsp_if.distance_squared)
);

### sim/tb.sv
// testbench for voronoi_nearest_seed_color_unit: predicted lookups checked against every response
`timescale 1ns / 100ps

module tb;

   localparam int CW           = vnsc_pkg::COORD_BITS_DEF;
   localparam int COORD_MAX    = (1 << CW) - 1;
   // drain margin after the last response, before a register write
   localparam int DRAIN_CYCLES = 2 * vnsc_pkg::MAX_SEEDS_DEF + 40;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_ITEMS  = 190;
   localparam int NUM_PHASES   = 9;
   // the block has no register at this index, a write there must change nothing
   localparam logic [vnsc_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // one request as it goes over the req channel
   typedef struct {
      logic                            kind;
      logic [vnsc_pkg::SLOT_W-1:0]     seed_index;
      logic [CW-1:0]                   seed_x;
      logic [CW-1:0]                   seed_y;
      logic [vnsc_pkg::COLOR_W-1:0]    seed_color;
      logic [CW-1:0]                   pixel_x;
      logic [CW-1:0]                   pixel_y;
   } stream_item_type;

   // one expected lookup response
   typedef struct {
      logic [vnsc_pkg::COLOR_W-1:0]    color_out;
      logic                            found;
      logic [vnsc_pkg::SLOT_W-1:0]     nearest_index;
      logic [vnsc_pkg::DIST_OUT_W-1:0] distance_squared;
   } lookup_type;

   logic clock;
   logic reset;

   vnsc_req_if #(.COORD_BITS(CW)) req_bus ();
   vnsc_rsp_if                    rsp_bus ();
   vnsc_csr_if                    csr_bus ();

   voronoi_nearest_seed_color_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus.sink),
      .rsp_if (rsp_bus.source),
      .csr_if (csr_bus.sink)
   );

   // predictor copy of the registers and the seed table
   logic [vnsc_pkg::WIDTH_W-1:0] cfg_width = vnsc_pkg::WIDTH_RESET;
   logic [vnsc_pkg::COUNT_W-1:0] cfg_count = vnsc_pkg::COUNT_RESET;
   logic [vnsc_pkg::COLOR_W-1:0] cfg_empty = vnsc_pkg::EMPTY_RESET;
   logic [CW-1:0]                seed_col   [vnsc_pkg::SLOT_LIMIT];
   logic [CW-1:0]                seed_row   [vnsc_pkg::SLOT_LIMIT];
   logic [vnsc_pkg::COLOR_W-1:0] seed_paint [vnsc_pkg::SLOT_LIMIT];

   // generator-side view of the table at the tail of the stream
   int plan_col    [vnsc_pkg::SLOT_LIMIT];
   int plan_row    [vnsc_pkg::SLOT_LIMIT];
   bit plan_loaded [vnsc_pkg::SLOT_LIMIT];

   stream_item_type stream_items [$];
   lookup_type      lookups_due  [$];
   stream_item_type offer;

   int  pushed_items   = 0;
   int  accepted_items = 0;
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  req_gap        = 0;
   int  rsp_stall      = 0;
   int  backlog_hold   = 0;
   bit  backlog_done   = 1'b0;
   bit  req_steady     = 1'b0;
   bit  rsp_steady     = 1'b0;

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // gap length: mostly none, some short, a few long
   function automatic int idle_length(input bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // nearest qualifying seed among the searched slots, lowest slot on a tie
   function automatic lookup_type nearest_seed_lookup(input logic [CW-1:0] px,
                                                      input logic [CW-1:0] py);
      logic [vnsc_pkg::LIMIT_W-1:0]    cutoff;
      logic [vnsc_pkg::LIMIT_W-1:0]    bound;
      logic [vnsc_pkg::DIST_OUT_W-1:0] cand_d;
      logic [CW-1:0]                   dx;
      logic [CW-1:0]                   dy;
      int                              searched;
      lookup_type                      res;
      cutoff   = vnsc_pkg::LIMIT_W'(cfg_width) * vnsc_pkg::LIMIT_W'(cfg_width);
      searched = (int'(cfg_count) > vnsc_pkg::SLOT_LIMIT) ? vnsc_pkg::SLOT_LIMIT
                                                         : int'(cfg_count);
      res.color_out        = cfg_empty;
      res.found            = 1'b0;
      res.nearest_index    = '0;
      res.distance_squared = '0;
      for (int t = 0; t < searched; t++) begin
         dx     = (px > seed_col[t]) ? px - seed_col[t] : seed_col[t] - px;
         dy     = (py > seed_row[t]) ? py - seed_row[t] : seed_row[t] - py;
         cand_d = vnsc_pkg::DIST_OUT_W'(dx) * vnsc_pkg::DIST_OUT_W'(dx) +
                  vnsc_pkg::DIST_OUT_W'(dy) * vnsc_pkg::DIST_OUT_W'(dy);
         bound = res.found ? vnsc_pkg::LIMIT_W'(res.distance_squared) : cutoff;
         if (vnsc_pkg::LIMIT_W'(cand_d) < bound) begin
            res.found            = 1'b1;
            res.distance_squared = cand_d;
            res.nearest_index    = vnsc_pkg::SLOT_W'(t);
            res.color_out        = seed_paint[t];
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- driver
   // offers queued items; on each transfer the predictor absorbs the item
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (offer.kind == vnsc_pkg::KIND_LOAD) begin
               seed_col[offer.seed_index]   = offer.seed_x;
               seed_row[offer.seed_index]   = offer.seed_y;
               seed_paint[offer.seed_index] = offer.seed_color;
            end else begin
               lookups_due.push_back(nearest_seed_lookup(offer.pixel_x, offer.pixel_y));
            end
            accepted_items++;
            req_gap = idle_length(req_steady);
         end
         // hold the item while the block stalls
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (stream_items.size() > 0) begin
               offer = stream_items.pop_front();
               req_bus.kind       <= offer.kind;
               req_bus.seed_index <= offer.seed_index;
               req_bus.seed_x     <= offer.seed_x;
               req_bus.seed_y     <= offer.seed_y;
               req_bus.seed_color <= offer.seed_color;
               req_bus.pixel_x    <= offer.pixel_x;
               req_bus.pixel_y    <= offer.pixel_y;
               req_bus.valid      <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   task automatic check_lookup();
      lookup_type want;
      if (lookups_due.size() == 0) begin
         $error("response with no lookup outstanding: color_out %h", rsp_bus.color_out);
         mismatch_count++;
      end else begin
         want = lookups_due.pop_front();
         if (rsp_bus.color_out !== want.color_out) begin
            $error("color_out: expected %h, got %h", want.color_out, rsp_bus.color_out);
            mismatch_count++;
         end
         if (rsp_bus.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp_bus.found);
            mismatch_count++;
         end
         if (rsp_bus.nearest_index !== want.nearest_index) begin
            $error("nearest_index: expected %0d, got %0d",
                   want.nearest_index, rsp_bus.nearest_index);
            mismatch_count++;
         end
         if (rsp_bus.distance_squared !== want.distance_squared) begin
            $error("distance_squared: expected %0d, got %0d",
                   want.distance_squared, rsp_bus.distance_squared);
            mismatch_count++;
         end
      end
   endtask

   // checks every response transfer and throttles ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_lookup();
            rsp_stall = idle_length(rsp_steady);
         end
         // one long hold-off mid-run so the chain backs up into the req side
         if (!backlog_done && accepted_items >= 700) begin
            backlog_hold = 500;
            backlog_done = 1'b1;
         end
         if (backlog_hold > 0) begin
            backlog_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic int clamp_coord(input int v);
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   function automatic int near_coord(input int center, input int reach);
      int off;
      off = $urandom_range(0, reach);
      return clamp_coord($urandom_range(0, 1) ? center + off : center - off);
   endfunction

   function automatic int edge_coord();
      return $urandom_range(0, 1) ? COORD_MAX : 0;
   endfunction

   task automatic push_query(input int x, input int y);
      stream_item_type it;
      it.kind       = vnsc_pkg::KIND_QUERY;
      it.seed_index = vnsc_pkg::SLOT_W'($urandom);
      it.seed_x     = CW'($urandom);
      it.seed_y     = CW'($urandom);
      it.seed_color = $urandom;
      it.pixel_x    = CW'(x);
      it.pixel_y    = CW'(y);
      stream_items.push_back(it);
      pushed_items++;
   endtask

   task automatic push_load(input int slot, input int x, input int y,
                            input logic [vnsc_pkg::COLOR_W-1:0] color);
      stream_item_type it;
      it.kind       = vnsc_pkg::KIND_LOAD;
      it.seed_index = vnsc_pkg::SLOT_W'(slot);
      it.seed_x     = CW'(x);
      it.seed_y     = CW'(y);
      it.seed_color = color;
      it.pixel_x    = CW'($urandom);
      it.pixel_y    = CW'($urandom);
      plan_col[slot]    = x;
      plan_row[slot]    = y;
      plan_loaded[slot] = 1'b1;
      stream_items.push_back(it);
      pushed_items++;
   endtask

   task automatic random_load(input int slot);
      int r;
      int src;
      int x;
      int y;
      r = $urandom_range(0, 99);
      src = $urandom_range(0, vnsc_pkg::SLOT_LIMIT - 1);
      if (r < 10 && plan_loaded[src]) begin
         // same spot as another seed, forces distance ties
         x = plan_col[src];
         y = plan_row[src];
      end else if (r < 18) begin
         x = edge_coord();
         y = edge_coord();
      end else begin
         x = $urandom_range(0, COORD_MAX);
         y = $urandom_range(0, COORD_MAX);
      end
      push_load(slot, x, y, $urandom);
   endtask

   task automatic random_query();
      int r;
      int t;
      int searched;
      int reach;
      searched = (int'(cfg_count) > vnsc_pkg::SLOT_LIMIT) ? vnsc_pkg::SLOT_LIMIT
                                                         : int'(cfg_count);
      r = $urandom_range(0, 99);
      if (searched > 0 && r < 70) begin
         // aim at a searched seed, sometimes right on it, mostly around the cutoff
         t = $urandom_range(0, searched - 1);
         if (r < 15) reach = 3;
         else if (cfg_width == 0) reach = 8;
         else reach = int'(cfg_width) + int'(cfg_width) / 4 + 1;
         if (reach > COORD_MAX) reach = COORD_MAX;
         push_query(near_coord(plan_col[t], reach), near_coord(plan_row[t], reach));
      end else if (r < 80) begin
         push_query(edge_coord(), edge_coord());
      end else begin
         push_query($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      end
   endtask

   // block is idle once every transfer has been absorbed and every response seen
   task automatic wait_idle();
      @(posedge clock);
      while (accepted_items != pushed_items || lookups_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [vnsc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [vnsc_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      case (idx)
         vnsc_pkg::CSR_IMAGE_WIDTH: cfg_width = value[vnsc_pkg::WIDTH_W-1:0];
         vnsc_pkg::CSR_SEED_COUNT:  cfg_count = value[vnsc_pkg::COUNT_W-1:0];
         vnsc_pkg::CSR_EMPTY_COLOR: cfg_empty = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input int width, input int count,
                             input logic [vnsc_pkg::COLOR_W-1:0] empty);
      wait_idle();
      write_reg(vnsc_pkg::CSR_IMAGE_WIDTH, vnsc_pkg::CSR_DATA_W'(width));
      write_reg(vnsc_pkg::CSR_SEED_COUNT, vnsc_pkg::CSR_DATA_W'(count));
      write_reg(vnsc_pkg::CSR_EMPTY_COLOR, empty);
   endtask

   initial begin
      int w;
      int c;
      logic [vnsc_pkg::COLOR_W-1:0] e;
      reset = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.kind       = vnsc_pkg::KIND_LOAD;
      req_bus.seed_index = '0;
      req_bus.seed_x     = '0;
      req_bus.seed_y     = '0;
      req_bus.seed_color = '0;
      req_bus.pixel_x    = '0;
      req_bus.pixel_y    = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = vnsc_pkg::CSR_IMAGE_WIDTH;
      csr_bus.data       = '0;
      for (int s = 0; s < vnsc_pkg::SLOT_LIMIT; s++) plan_loaded[s] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // zero count right after reset: empty color, nothing found
      push_query(0, 0);
      push_query(COORD_MAX, COORD_MAX);
      push_load(0, 0, 0, 32'hFFFF_FFFF);
      push_load(1, COORD_MAX, COORD_MAX, 32'h0000_0000);
      push_load(2, 2000, 1000, 32'h1234_5678);
      // slot 3 sits on slot 2, the lower slot must win the tie
      push_load(3, 2000, 1000, 32'h9ABC_DEF0);
      push_load(63, COORD_MAX, 0, 32'hA5A5_A5A5);
      push_query(0, 0);

      // full-width cutoff, four seeds searched
      set_config(4096, 4, 32'h5A5A_0F0F);
      push_query(0, 0);
      push_query(COORD_MAX, COORD_MAX);
      push_query(2000, 1000);
      push_query(2003, 1004);
      push_query(0, COORD_MAX);
      push_query(COORD_MAX, 0);

      // width 1: only an exact hit qualifies
      set_config(1, 4, 32'h0000_0000);
      push_query(0, 0);
      push_query(1, 0);
      push_query(2000, 1000);

      // zero width: nothing qualifies even on top of a seed
      set_config(0, 4, 32'hFFFF_FFFF);
      push_query(2000, 1000);

      // widest cutoff, largest possible distance
      set_config(8191, 1, 32'h0F0F_F0F0);
      push_query(COORD_MAX, COORD_MAX);

      for (int p = 0; p < NUM_PHASES; p++) begin
         e = $urandom;
         case (p)
            0: begin w = 256;  c = 4; end
            1: begin w = 4096; c = 64;  e = 32'h0000_0000; end
            2: begin w = 1;    c = 65;  e = 32'hFFFF_FFFF; end
            3: begin w = 0;    c = 127; end
            4: begin w = 8191; c = 1; end
            5: begin w = $urandom_range(1, 4096); c = 0; end
            6: begin w = 4095; c = 63;  e = 32'h0000_0000; end
            7: begin w = $urandom_range(1, 600); c = $urandom_range(0, 127); end
            default: begin w = $urandom_range(0, 8191); c = 64; e = 32'hFFFF_FFFF; end
         endcase
         set_config(w, c, e);
         if (p == 4) write_reg(CSR_UNUSED, $urandom);
         req_steady = (p == 1) || ($urandom_range(0, 3) == 0);
         rsp_steady = (p == 1) || ($urandom_range(0, 3) == 0);
         // first phase fills every slot so later phases may search all of them
         if (p == 0) begin
            for (int s = 0; s < vnsc_pkg::SLOT_LIMIT; s++) begin
               if (!plan_loaded[s]) begin
                  random_load(s);
                  if ($urandom_range(0, 1)) random_query();
               end
            end
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 25) begin
               random_load($urandom_range(0, vnsc_pkg::SLOT_LIMIT - 1));
            end else begin
               random_query();
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0 && lookups_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
